[rtl/core/sfla_pkg.sv]
package sfla_pkg;

  localparam int PAGE_BYTES    = 4096;
  localparam int MIN_CLASS_EXP = 4;
  localparam int MAX_CLASS_EXP = 12;
  localparam int HEAP_BYTES    = 1048576;

  localparam int NUM_CLASSES = MAX_CLASS_EXP - MIN_CLASS_EXP + 1;
  localparam int CLASS_W     = $clog2(NUM_CLASSES);
  localparam int LINK_DEPTH  = HEAP_BYTES >> MIN_CLASS_EXP;
  localparam int LINK_AW     = $clog2(LINK_DEPTH);
  localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);

  localparam int SIZE_W  = 13;
  localparam int OFF_W   = 20;
  localparam int FREE_W  = 21;
  localparam int LIMIT_W = 9;
  localparam int TOP_W   = $clog2(HEAP_BYTES + 1);
  localparam int CSIZE_W = MAX_CLASS_EXP + 1;
  localparam int LIM_W   = LIMIT_W + PAGE_SHIFT;

  localparam int FIFO_DEPTH = 2;

  localparam logic [LIMIT_W-1:0] HEAP_LIMIT_RESET = LIMIT_W'(256);

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_BIG   = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic REG_HEAP_LIMIT = 1'b0;

  typedef struct packed {
    logic              opcode;
    logic [SIZE_W-1:0] size_bytes;
    logic [OFF_W-1:0]  offset;
  } req_t;

  typedef struct packed {
    logic [OFF_W-1:0]  result_offset;
    logic [1:0]        status;
    logic [FREE_W-1:0] free_bytes;
  } resp_t;

  // classified command passed from front to back
  typedef struct packed {
    logic               opcode;
    logic               too_big;
    logic [CLASS_W-1:0] cls;
    logic [OFF_W-1:0]   offset;
  } cmd_t;

  function automatic logic [CSIZE_W-1:0] class_size(input logic [CLASS_W-1:0] c);
    return CSIZE_W'(1) << (int'(c) + MIN_CLASS_EXP);
  endfunction

  // bytes taken from the heap top on a refill
  function automatic logic [TOP_W-1:0] grow_size(input logic [CLASS_W-1:0] c);
    logic [CSIZE_W-1:0] cs;
    cs = class_size(c);
    if (int'(cs) > PAGE_BYTES) begin
      return TOP_W'(cs);
    end
    return TOP_W'(PAGE_BYTES);
  endfunction

endpackage

[rtl/core/sfla_ram.sv]
module sfla_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/sfla_front.sv]
module sfla_front
  import sfla_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic cmd_valid,
  output cmd_t cmd,
  input  logic cmd_take
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t             entries [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  cmd_t             classified;
  logic             push;
  logic             pop;

  // class = number of class bounds the size exceeds
  always_comb begin
    classified         = '0;
    classified.opcode  = req.opcode;
    classified.offset  = req.offset;
    classified.too_big = int'(req.size_bytes) > (1 << MAX_CLASS_EXP);
    for (int k = 0; k < NUM_CLASSES - 1; k++) begin
      classified.cls = classified.cls
                     + CLASS_W'(int'(req.size_bytes) > (1 << (k + MIN_CLASS_EXP)));
    end
  end

  assign busy      = (count == CNT_W'(FIFO_DEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (count != '0);
  assign pop       = cmd_take && cmd_valid;
  assign cmd       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= classified;
        wr_ptr          <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/core/sfla_back.sv]
module sfla_back
  import sfla_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [LIMIT_W-1:0] heap_limit_pages,
  input  logic               cmd_valid,
  input  cmd_t               cmd_in,
  output logic               cmd_take,
  output logic               result_valid,
  output resp_t              result
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_CARVE, S_READ} state_t;

  state_t            state;
  cmd_t              cmd;
  logic [OFF_W-1:0]  heads [NUM_CLASSES];
  logic [TOP_W-1:0]  heap_top;
  logic [FREE_W-1:0] free_count;
  logic [TOP_W-1:0]  carve_addr;
  logic [TOP_W-1:0]  carve_end;

  logic [OFF_W-1:0]   head_cur;
  logic [CSIZE_W-1:0] csize;
  logic [TOP_W-1:0]   grow;
  logic [LIM_W-1:0]   lim_raw;
  logic [TOP_W:0]     limit;
  logic [TOP_W:0]     need_top;
  logic [TOP_W-1:0]   carve_next;
  logic               carve_last;
  logic               free_ok;
  logic [FREE_W-1:0]  free_add;
  logic [FREE_W-1:0]  free_sub;

  logic               ram_we;
  logic [LINK_AW-1:0] ram_addr;
  logic [OFF_W-1:0]   ram_wdata;
  logic [OFF_W-1:0]   ram_rdata;

  assign head_cur   = heads[cmd.cls];
  assign csize      = class_size(cmd.cls);
  assign grow       = grow_size(cmd.cls);
  assign lim_raw    = LIM_W'(heap_limit_pages) << PAGE_SHIFT;
  assign limit      = ((LIM_W + 1)'(lim_raw) > (LIM_W + 1)'(HEAP_BYTES))
                    ? (TOP_W + 1)'(HEAP_BYTES) : (TOP_W + 1)'(lim_raw);
  assign need_top   = (TOP_W + 1)'(heap_top) + (TOP_W + 1)'(grow);
  assign carve_next = carve_addr + TOP_W'(csize);
  assign carve_last = (carve_next == carve_end);
  assign free_ok    = (cmd.offset != '0) && (TOP_W'(cmd.offset) < heap_top);
  assign free_add   = free_count + FREE_W'(csize);
  assign free_sub   = free_count - FREE_W'(csize);
  assign cmd_take   = (state == S_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = cmd.offset[MIN_CLASS_EXP +: LINK_AW];
    ram_wdata = head_cur;
    case (state)
      S_EXEC: begin
        if (!cmd.too_big && cmd.opcode == OP_FREE) begin
          ram_we = free_ok;
        end else if (!cmd.too_big) begin
          ram_addr = head_cur[MIN_CLASS_EXP +: LINK_AW];
        end
      end
      S_CARVE: begin
        ram_we    = 1'b1;
        ram_addr  = carve_addr[MIN_CLASS_EXP +: LINK_AW];
        ram_wdata = carve_last ? '0 : carve_next[OFF_W-1:0];
      end
      default: ;
    endcase
  end

  sfla_ram #(
    .WIDTH(OFF_W),
    .DEPTH(LINK_DEPTH)
  ) u_links (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      heap_top     <= TOP_W'(PAGE_BYTES);
      free_count   <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        heads[i] <= '0;
      end
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd   <= cmd_in;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd.too_big) begin
            result       <= '{result_offset: '0, status: ST_TOO_BIG, free_bytes: free_count};
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else if (cmd.opcode == OP_FREE) begin
            if (free_ok) begin
              heads[cmd.cls] <= cmd.offset;
              free_count     <= free_add;
              result <= '{result_offset: '0, status: ST_OK, free_bytes: free_add};
            end else begin
              result <= '{result_offset: '0, status: ST_OK, free_bytes: free_count};
            end
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else if (head_cur != '0) begin
            state <= S_READ;
          end else if (need_top > limit) begin
            result       <= '{result_offset: '0, status: ST_EXHAUSTED, free_bytes: free_count};
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else begin
            carve_addr <= heap_top;
            carve_end  <= need_top[TOP_W-1:0];
            state      <= S_CARVE;
          end
        end
        S_CARVE: begin
          // one link per cycle; on the last chunk publish the new list and retry the pop
          if (carve_last) begin
            heads[cmd.cls] <= heap_top[OFF_W-1:0];
            heap_top       <= carve_end;
            free_count     <= free_count + FREE_W'(grow);
            state          <= S_EXEC;
          end else begin
            carve_addr <= carve_next;
          end
        end
        S_READ: begin
          heads[cmd.cls] <= ram_rdata;
          free_count     <= free_sub;
          result         <= '{result_offset: head_cur, status: ST_OK, free_bytes: free_sub};
          result_valid   <= 1'b1;
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/segregated_free_list_allocator_top.sv]
// Sequence: a command taken in IDLE runs EXEC; an alloc from a non-empty list then reads
// the link RAM in READ before the result strobe; a free or an error strobes from EXEC.
// A refill runs CARVE, one link write per chunk, then retries EXEC (PAGE_BYTES / chunk
// size chunks, 256 for the smallest class). A new command is taken only in IDLE;
// a two-entry queue lets start be taken while the back end works; busy marks it full.
// Reset: synchronous; clears class heads, heap top, free count (not link RAM).
module segregated_free_list_allocator_top
  import sfla_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  req_t        req,
  output logic        busy,
  output logic        result_valid,
  output resp_t       result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [LIMIT_W-1:0] heap_limit_pages;
  logic               cmd_valid;
  cmd_t               cmd;
  logic               cmd_take;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEAP_LIMIT) ? 32'(heap_limit_pages) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit_pages <= HEAP_LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_HEAP_LIMIT) begin
      heap_limit_pages <= pwdata[LIMIT_W-1:0];
    end
  end

  sfla_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .busy     (busy),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take)
  );

  sfla_back u_back (
    .clk             (clk),
    .rst             (rst),
    .heap_limit_pages(heap_limit_pages),
    .cmd_valid       (cmd_valid),
    .cmd_in          (cmd),
    .cmd_take        (cmd_take),
    .result_valid    (result_valid),
    .result          (result)
  );

endmodule

[sim/tb_segregated_free_list_allocator_top.sv]
`timescale 1ns / 1ps

module tb_segregated_free_list_allocator_top;
  import sfla_pkg::*;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int SETTLE_CYCLES   = 20;
  localparam int MAX_REPORTS     = 10;
  localparam int LIVE_CAP        = 120;

  localparam logic [2:0] LIMIT_ADDR = 3'(4 * int'(REG_HEAP_LIMIT));

  typedef struct {
    logic [OFF_W-1:0] offset;
    int               cls;
  } live_chunk_t;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        start   = 1'b0;
  req_t        req     = '0;
  logic        busy;
  logic        result_valid;
  resp_t       result;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // allocator mirror
  logic [OFF_W-1:0]   head_mirror [NUM_CLASSES];
  bit   [OFF_W-1:0]   link_mirror [LINK_DEPTH];
  longint             top_mirror;
  logic [FREE_W-1:0]  free_mirror;
  logic [LIMIT_W-1:0] limit_mirror;

  resp_t       resp_due[$];
  live_chunk_t live_chunks[$];
  int          err_cnt      = 0;
  int          quiet_cycles = 0;

  always #5 clk = ~clk;

  segregated_free_list_allocator_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req          (req),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  task automatic note_error(input string msg);
    if (err_cnt < MAX_REPORTS) begin
      $display("%0t mismatch: %s", $time, msg);
    end
    err_cnt++;
  endtask

  // smallest class that holds sz, NUM_CLASSES when too big
  function automatic int class_index(input logic [SIZE_W-1:0] sz);
    int e = 0;
    while ((longint'(1) << e) < longint'(sz)) e++;
    if (e < MIN_CLASS_EXP) e = MIN_CLASS_EXP;
    if (e > MAX_CLASS_EXP) return NUM_CLASSES;
    return e - MIN_CLASS_EXP;
  endfunction

  function automatic int chunk_bytes(input int c);
    return 1 << (c + MIN_CLASS_EXP);
  endfunction

  // take fresh space off the heap top and link it up as chunks of class c
  function automatic bit carve_page(input int c);
    longint csize, grow, lim, cnt, here, i;
    csize = chunk_bytes(c);
    grow  = (csize > PAGE_BYTES) ? csize : PAGE_BYTES;
    lim   = longint'(limit_mirror) * PAGE_BYTES;
    if (lim > HEAP_BYTES) lim = HEAP_BYTES;
    if (top_mirror + grow > lim) return 1'b0;
    cnt = grow / csize;
    for (i = 0; i < cnt; i++) begin
      here = top_mirror + i * csize;
      link_mirror[here >> MIN_CLASS_EXP] = (i + 1 < cnt) ? OFF_W'(here + csize) : '0;
    end
    head_mirror[c] = OFF_W'(top_mirror);
    top_mirror     = top_mirror + grow;
    free_mirror    = free_mirror + FREE_W'(cnt * csize);
    return 1'b1;
  endfunction

  function automatic resp_t apply_request(input req_t r);
    resp_t rsp;
    int    c;
    rsp = '0;
    rsp.status = ST_OK;
    c = class_index(r.size_bytes);
    if (c >= NUM_CLASSES) begin
      rsp.status = ST_TOO_BIG;
    end else if (r.opcode == OP_ALLOC) begin
      if (head_mirror[c] == '0) begin
        if (!carve_page(c)) rsp.status = ST_EXHAUSTED;
      end
      if (rsp.status == ST_OK) begin
        rsp.result_offset = head_mirror[c];
        head_mirror[c]    = link_mirror[head_mirror[c] >> MIN_CLASS_EXP];
        free_mirror       = free_mirror - FREE_W'(chunk_bytes(c));
        live_chunks.push_back('{rsp.result_offset, c});
      end
    end else if (r.offset != '0 && longint'(r.offset) < top_mirror) begin
      link_mirror[r.offset >> MIN_CLASS_EXP] = head_mirror[c];
      head_mirror[c] = r.offset;
      free_mirror    = free_mirror + FREE_W'(chunk_bytes(c));
    end
    rsp.free_bytes = free_mirror;
    return rsp;
  endfunction

  function automatic req_t make_req(input logic op, input int sz, input int off);
    req_t r;
    r.opcode     = op;
    r.size_bytes = SIZE_W'(sz);
    r.offset     = OFF_W'(off);
    return r;
  endfunction

  // random size that lands in class c
  function automatic int size_in_class(input int c);
    if (c == 0) return $urandom_range(0, 16);
    return $urandom_range((1 << (c + MIN_CLASS_EXP - 1)) + 1, 1 << (c + MIN_CLASS_EXP));
  endfunction

  task automatic send_item(input req_t r);
    req   <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    resp_due.push_back(apply_request(r));
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (resp_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write, then read back in a second back-to-back transfer
  task automatic write_heap_limit(input logic [LIMIT_W-1:0] pages);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= 32'(pages);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    limit_mirror = pages;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[LIMIT_W-1:0] !== pages) begin
      note_error($sformatf("heap_limit_pages readback exp %0d got %0d", pages,
                           rd[LIMIT_W-1:0]));
    end
  endtask

  task automatic test_directed_cases();
    send_item(make_req(OP_ALLOC, 0, 0));            // refill of the smallest class
    send_item(make_req(OP_ALLOC, 1, 0));
    send_item(make_req(OP_ALLOC, 16, 0));
    send_item(make_req(OP_ALLOC, 17, 0));
    send_item(make_req(OP_ALLOC, 4096, 0));         // largest class, one chunk per refill
    send_item(make_req(OP_ALLOC, 4095, 'hFFFFF));
    send_item(make_req(OP_ALLOC, 4097, 0));         // too big
    send_item(make_req(OP_ALLOC, 8191, 0));
    send_item(make_req(OP_FREE, 8191, 4096));       // too big on free changes nothing
    send_item(make_req(OP_FREE, 16, 0));            // header offset ignored
    send_item(make_req(OP_FREE, 16, 'hFFFFF));      // above heap top ignored
    send_item(make_req(OP_FREE, 16, 4096));
    send_item(make_req(OP_ALLOC, 8, 0));
    for (int c = 2; c < NUM_CLASSES - 1; c++) begin
      send_item(make_req(OP_ALLOC, chunk_bytes(c), 0));
    end
    send_item(make_req(OP_FREE, 100, 4097));        // misaligned, wrong-class push
    send_item(make_req(OP_ALLOC, 100, 0));
    send_item(make_req(OP_FREE, 16, 4112));         // double free
    send_item(make_req(OP_FREE, 16, 4112));
    send_item(make_req(OP_ALLOC, 16, 0));
    send_item(make_req(OP_ALLOC, 16, 0));
  endtask

  task automatic test_heap_limit_extremes();
    write_heap_limit(LIMIT_W'(2));
    for (int c = 0; c < NUM_CLASSES; c++) begin
      send_item(make_req(OP_ALLOC, size_in_class(c), $urandom));
    end
    wait_idle();
    write_heap_limit('0);
    for (int k = 0; k < 4; k++) begin
      send_item(make_req(OP_ALLOC, size_in_class(NUM_CLASSES - 1 - k), 0));
    end
    wait_idle();
  endtask

  task automatic run_random_traffic(input int n_items, input bit with_gaps);
    req_t r;
    int   pick;
    int   idx;
    bit   gaps_now;
    gaps_now = with_gaps;
    for (int k = 0; k < n_items; k++) begin
      if (with_gaps && $urandom_range(0, 39) == 0) gaps_now = !gaps_now;
      r        = '0;
      r.offset = OFF_W'($urandom);
      pick     = $urandom_range(0, 99);
      if (pick < 50 && live_chunks.size() > LIVE_CAP) pick = 70;
      if (pick < 50) begin
        r.opcode     = OP_ALLOC;
        r.size_bytes = SIZE_W'(size_in_class($urandom_range(0, NUM_CLASSES - 1)));
      end else if (pick < 88 && live_chunks.size() != 0) begin
        // give back something handed out earlier, size anywhere in its class
        idx          = $urandom_range(0, live_chunks.size() - 1);
        r.opcode     = OP_FREE;
        r.offset     = live_chunks[idx].offset;
        r.size_bytes = SIZE_W'(size_in_class(live_chunks[idx].cls));
        live_chunks.delete(idx);
      end else begin
        r.opcode = ($urandom_range(0, 1) == 0) ? OP_ALLOC : OP_FREE;
        if ($urandom_range(0, 3) == 0) r.size_bytes = SIZE_W'($urandom_range(4097, 8191));
        else r.size_bytes = SIZE_W'($urandom);
        case ($urandom_range(0, 2))
          0:       r.offset = '0;
          1:       r.offset = OFF_W'($urandom_range(1, int'(top_mirror) - 1));
          default: r.offset = OFF_W'($urandom);
        endcase
      end
      send_item(r);
      if (gaps_now && $urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 15));
    end
  endtask

  task automatic test_random_traffic();
    write_heap_limit('1);                        // clamps to the full heap
    run_random_traffic(230, 1'b1);
    wait_idle();
    write_heap_limit(LIMIT_W'($urandom_range(2, 511)));
    run_random_traffic(230, 1'b1);
    wait_idle();
    write_heap_limit(LIMIT_W'(2));
    run_random_traffic(180, 1'b1);
    wait_idle();
    write_heap_limit(LIMIT_W'($urandom_range(2, 511)));
    run_random_traffic(230, 1'b1);
    wait_idle();
    write_heap_limit(HEAP_LIMIT_RESET);
    run_random_traffic(230, 1'b0);
  endtask

  always @(posedge clk) begin
    resp_t want;
    if (!rst && result_valid) begin
      if (resp_due.size() == 0) begin
        note_error($sformatf("unexpected result off=%h st=%0d free=%0d",
                             result.result_offset, result.status, result.free_bytes));
      end else begin
        want = resp_due.pop_front();
        if (result.result_offset !== want.result_offset || result.status !== want.status ||
            result.free_bytes !== want.free_bytes) begin
          note_error($sformatf("exp off=%h st=%0d free=%0d, got off=%h st=%0d free=%0d",
                               want.result_offset, want.status, want.free_bytes,
                               result.result_offset, result.status, result.free_bytes));
        end
      end
    end
  end

  // counts cycles in which neither side nor the register port moves anything
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (head_mirror[c]) head_mirror[c] = '0;
    top_mirror   = PAGE_BYTES;
    free_mirror  = '0;
    limit_mirror = HEAP_LIMIT_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    wait_idle();
    test_heap_limit_extremes();
    test_random_traffic();
    wait_idle();
    if (err_cnt == 0 && resp_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
